[sv/ahos_pkg.sv]
package ahos_pkg;

	localparam int DATA_WIDTH_DEF   = 32;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] RAD_TO_TURN     = 32'd683565276;

	localparam logic [31:0] FREQ_GAIN_RST     = 32'd65536;
	localparam logic [31:0] AMP_GAIN_RST      = 32'd65536;
	localparam logic [31:0] TIME_STEP_RST     = 32'd4294967;
	localparam logic [31:0] INV_TIME_STEP_RST = 32'd65536000;

	localparam logic [1:0] REG_FREQ_GAIN     = 2'd0;
	localparam logic [1:0] REG_AMP_GAIN      = 2'd1;
	localparam logic [1:0] REG_TIME_STEP     = 2'd2;
	localparam logic [1:0] REG_INV_TIME_STEP = 2'd3;

	localparam logic [29:0] ATAN_TURNS [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
	};

	typedef struct packed {
		logic signed [31:0] measured_position;
		logic               new_order_valid;
		logic signed [31:0] new_order;
	} ahos_in_t;

	typedef struct packed {
		logic signed [31:0] position_order;
		logic signed [31:0] speed_order;
		logic        [31:0] phase_out;
		logic signed [31:0] amplitude_out;
	} ahos_out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ERR, S_COS0, S_EC, S_TG, S_FQ, S_RAD, S_PH,
		S_SIN1, S_ES, S_AG, S_AM, S_POS, S_SPD, S_DONE
	} ahos_state_t;

endpackage

[sv/ahos_mul.sv]
module ahos_mul #(
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] a,
	input  logic        [31:0]   b_mag,
	input  logic                 b_neg,
	output logic                 busy,
	output logic                 done,
	output logic                 neg,
	output logic        [DW+31:0] prod
);
	import ahos_pkg::*;

	logic            busy_q, done_q, neg_q;
	logic [5:0]      cnt_q;
	logic [DW-1:0]   a_mag, amag_q;
	logic [31:0]     b_q;
	logic [DW+31:0]  acc_q;

	assign a_mag = a[DW-1] ? DW'(-a) : DW'(a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			amag_q <= a_mag;
			b_q    <= b_mag;
			neg_q  <= a[DW-1] ^ b_neg;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1) + (b_q[31] ? {32'b0, amag_q} : '0);
			b_q   <= b_q << 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign neg  = neg_q;
	assign prod = acc_q;

endmodule

[sv/ahos_cordic.sv]
module ahos_cordic #(
	parameter int DW    = 32,
	parameter int STEPS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic        [31:0]   angle,
	output logic                 done,
	output logic signed [DW-1:0] sin_v,
	output logic signed [DW-1:0] cos_v
);
	import ahos_pkg::*;

	localparam int CW = $clog2(STEPS + 1);
	localparam int WW = DW + 22;

	logic                 busy_q, done_q, flip_q;
	logic [CW-1:0]        cnt_q;
	logic signed [33:0]   x_q, y_q, z_q;
	logic signed [DW-1:0] sin_q, cos_q;
	logic [31:0]          rot, p;
	logic                 flip;
	logic [CW+4:0]        cnt_ext;
	logic [4:0]           idx;
	logic signed [33:0]   dx, dy, at, xf, yf;

	function automatic logic signed [DW-1:0] round_sat(input logic signed [33:0] v);
		logic [33:0]        mag;
		logic [34:0]        r;
		logic signed [21:0] q;
		logic signed [WW-1:0] w, hi, lo;
		mag = v[33] ? 34'(-v) : 34'(v);
		r   = {1'b0, mag} + 35'd8192;
		q   = v[33] ? -$signed({1'b0, r[34:14]}) : $signed({1'b0, r[34:14]});
		w   = WW'(q);
		hi  = WW'($signed({1'b0, {(DW-1){1'b1}}}));
		lo  = -hi - WW'(1);
		if (w > hi)
			return hi[DW-1:0];
		else if (w < lo)
			return lo[DW-1:0];
		else
			return w[DW-1:0];
	endfunction

	assign rot     = angle + 32'h4000_0000;
	assign flip    = rot[31];
	assign p       = flip ? angle + 32'h8000_0000 : angle;
	assign cnt_ext = {5'b0, cnt_q};
	assign idx     = cnt_ext[4:0];
	assign dx      = y_q >>> idx;
	assign dy      = x_q >>> idx;
	assign at      = $signed({4'b0, ATAN_TURNS[idx]});
	assign xf      = flip_q ? -x_q : x_q;
	assign yf      = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({2'b0, CORDIC_GAIN_Q30});
			y_q    <= '0;
			z_q    <= 34'($signed(p));
			flip_q <= flip;
		end else if (busy_q) begin
			if (cnt_q == CW'(STEPS)) begin
				sin_q <= round_sat(yf);
				cos_q <= round_sat(xf);
			end else if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule

[sv/adaptive_hopf_oscillator_step_core.sv]
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_data  (ahos_in_t)
// out     | out | out_valid/out_stall| out_data (ahos_out_t)
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// Each item is computed in turn by the bit-serial shared multiplier (one bit per cycle,
// ten products) and the shared CORDIC (one rotation per cycle, two passes).
// in_stall is high from accept until the result is loaded into the output register.
// Reset clears the oscillator state and loads register defaults.
// A stalled result holds; the next item may be taken while it waits.
module adaptive_hopf_oscillator_step_core #(
	parameter int DATA_WIDTH   = ahos_pkg::DATA_WIDTH_DEF,
	parameter int CORDIC_STEPS = ahos_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ahos_pkg::ahos_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ahos_pkg::ahos_out_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ahos_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int WW = DW + 34;

	ahos_state_t state_q, state_d;

	logic [31:0] freq_gain_q, amp_gain_q, time_step_q, inv_time_step_q;
	logic signed [DW-1:0] freq_q, amp_q, last_order_q, meas_q, err_q;
	logic signed [DW-1:0] c0_q, s1_q, tmp_q, t_q, pos_q, speed_q;
	logic [31:0] phase_q;
	logic        op_issued_q, out_valid_q;
	ahos_out_t   out_q;

	logic                 mul_start, mul_busy, mul_done, mul_neg, mul_state, cor_state;
	logic                 cor_start, cor_done, shift32, b_neg;
	logic signed [DW-1:0] mul_a, cor_sin, cor_cos, mres, phid, dpos;
	logic [31:0]          b_mag;
	logic [DW+31:0]       prod, prod_tc;
	logic [31:0]          cor_angle;
	logic                 accept;

	function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] w);
		logic signed [WW-1:0] hi, lo;
		hi = WW'($signed({1'b0, {(DW-1){1'b1}}}));
		lo = -hi - WW'(1);
		if (w > hi)
			return hi[DW-1:0];
		else if (w < lo)
			return lo[DW-1:0];
		else
			return w[DW-1:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [DW-1:0] v);
		logic signed [WW-1:0] w, hi, lo;
		w  = WW'(v);
		hi = WW'($signed(33'h0_7FFF_FFFF));
		lo = -hi - WW'(1);
		if (w > hi)
			return 32'sh7FFF_FFFF;
		else if (w < lo)
			return 32'sh8000_0000;
		else
			return w[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [DW-1:0] v);
		logic [DW+31:0] m;
		m = {32'b0, (v[DW-1] ? DW'(-v) : DW'(v))};
		return m[31:0];
	endfunction

	function automatic logic signed [DW-1:0] mul_fin(input logic n, input logic [DW+31:0] pr,
			input logic s32);
		logic [DW+31:0] sh, lim;
		logic [DW-1:0]  m;
		sh  = s32 ? (pr >> 32) : (pr >> 16);
		lim = (DW+32)'({1'b0, {(DW-1){1'b1}}}) + (DW+32)'(n);
		m   = (sh > lim) ? lim[DW-1:0] : sh[DW-1:0];
		return n ? DW'(-m) : DW'(m);
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign phid    = sat_w(WW'(freq_q) - WW'(t_q));
	assign dpos    = sat_w(WW'(pos_q) - WW'(last_order_q));
	assign mres    = mul_fin(mul_neg, prod, shift32);
	assign prod_tc = mul_neg ? -prod : prod;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_ERR;
			S_ERR:  state_d = S_COS0;
			S_COS0: if (cor_done) state_d = S_EC;
			S_EC:   if (mul_done) state_d = S_TG;
			S_TG:   if (mul_done) state_d = S_FQ;
			S_FQ:   if (mul_done) state_d = S_RAD;
			S_RAD:  if (mul_done) state_d = S_PH;
			S_PH:   if (mul_done) state_d = S_SIN1;
			S_SIN1: if (cor_done) state_d = S_ES;
			S_ES:   if (mul_done) state_d = S_AG;
			S_AG:   if (mul_done) state_d = S_AM;
			S_AM:   if (mul_done) state_d = S_POS;
			S_POS:  if (mul_done) state_d = S_SPD;
			S_SPD:  if (mul_done) state_d = S_DONE;
			S_DONE: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mul_state = 1'b0;
		cor_state = 1'b0;
		mul_a     = err_q;
		b_mag     = '0;
		b_neg     = 1'b0;
		shift32   = 1'b0;
		cor_angle = phase_q;
		case (state_q)
			S_COS0: cor_state = 1'b1;
			S_SIN1: cor_state = 1'b1;
			S_EC: begin
				mul_state = 1'b1;
				b_mag     = mag32(c0_q);
				b_neg     = c0_q[DW-1];
			end
			S_TG: begin
				mul_state = 1'b1;
				mul_a     = tmp_q;
				b_mag     = freq_gain_q;
			end
			S_FQ: begin
				mul_state = 1'b1;
				mul_a     = t_q;
				b_mag     = time_step_q;
				shift32   = 1'b1;
			end
			S_RAD: begin
				mul_state = 1'b1;
				mul_a     = phid;
				b_mag     = time_step_q;
				shift32   = 1'b1;
			end
			S_PH: begin
				mul_state = 1'b1;
				mul_a     = tmp_q;
				b_mag     = RAD_TO_TURN;
			end
			S_ES: begin
				mul_state = 1'b1;
				b_mag     = mag32(s1_q);
				b_neg     = s1_q[DW-1];
			end
			S_AG: begin
				mul_state = 1'b1;
				mul_a     = tmp_q;
				b_mag     = amp_gain_q;
			end
			S_AM: begin
				mul_state = 1'b1;
				mul_a     = tmp_q;
				b_mag     = time_step_q;
				shift32   = 1'b1;
			end
			S_POS: begin
				mul_state = 1'b1;
				mul_a     = amp_q;
				b_mag     = mag32(s1_q);
				b_neg     = s1_q[DW-1];
			end
			S_SPD: begin
				mul_state = 1'b1;
				mul_a     = dpos;
				b_mag     = inv_time_step_q;
			end
			default: ;
		endcase
		mul_start = mul_state && !op_issued_q;
		cor_start = cor_state && !op_issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_issued_q     <= 1'b0;
			out_valid_q     <= 1'b0;
			freq_gain_q     <= FREQ_GAIN_RST;
			amp_gain_q      <= AMP_GAIN_RST;
			time_step_q     <= TIME_STEP_RST;
			inv_time_step_q <= INV_TIME_STEP_RST;
			freq_q          <= '0;
			amp_q           <= '0;
			last_order_q    <= '0;
			phase_q         <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || cor_start)
				op_issued_q <= 1'b1;
			else if (mul_done || cor_done)
				op_issued_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_FREQ_GAIN:     freq_gain_q     <= cfg_data;
					REG_AMP_GAIN:      amp_gain_q      <= cfg_data;
					REG_TIME_STEP:     time_step_q     <= cfg_data;
					REG_INV_TIME_STEP: inv_time_step_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && in_data.new_order_valid)
				last_order_q <= sat_w(WW'(in_data.new_order));
			if (state_q == S_FQ && mul_done)
				freq_q <= sat_w(WW'(freq_q) + WW'(mres));
			if (state_q == S_PH && mul_done)
				phase_q <= prod_tc[47:16];
			if (state_q == S_AM && mul_done)
				amp_q <= sat_w(WW'(amp_q) + WW'(mres));
			if (state_q == S_SPD && mul_done)
				last_order_q <= pos_q;
			if (state_q == S_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			meas_q <= sat_w(WW'(in_data.measured_position));
		if (state_q == S_ERR)
			err_q <= sat_w(WW'(meas_q) - WW'(last_order_q));
		if (state_q == S_COS0 && cor_done)
			c0_q <= cor_cos;
		if (state_q == S_SIN1 && cor_done)
			s1_q <= cor_sin;
		if (mul_done) begin
			case (state_q)
				S_EC, S_RAD, S_ES, S_AG: tmp_q <= mres;
				S_TG:  t_q     <= mres;
				S_POS: pos_q   <= mres;
				S_SPD: speed_q <= mres;
				default: ;
			endcase
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_q.position_order <= clamp32(pos_q);
			out_q.speed_order    <= clamp32(speed_q);
			out_q.phase_out      <= phase_q;
			out_q.amplitude_out  <= clamp32(amp_q);
		end
	end

	ahos_mul #(.DW(DW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b_mag  (b_mag),
		.b_neg  (b_neg),
		.busy   (mul_busy),
		.done   (mul_done),
		.neg    (mul_neg),
		.prod   (prod)
	);

	ahos_cordic #(.DW(DW), .STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.done   (cor_done),
		.sin_v  (cor_sin),
		.cos_v  (cor_cos)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("block not busy after accept");
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier restarted while busy");
	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_COS0 || state_q == S_SIN1))
		else $error("unexpected cordic completion");
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> mul_state)
		else $error("unexpected multiplier completion");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_stall) |=> out_valid)
		else $error("result not presented");
`endif

endmodule

[tb/adaptive_hopf_oscillator_step_core_tb.sv]
`timescale 1ns / 100ps

module adaptive_hopf_oscillator_step_core_tb;
	import ahos_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	ahos_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	ahos_out_t   out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	adaptive_hopf_oscillator_step_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// oscillator mirror
	bit [31:0]   g_freq, g_amp, g_dt, g_inv_dt;
	longint      osc_freq, osc_amp, osc_order;
	bit [31:0]   osc_phase;

	ahos_in_t    pending_beats[$];
	ahos_out_t   expected_beats[$];
	int          errors;
	int          snd_idle_pct, rcv_idle_pct;
	int          hold_left;
	bit          in_took;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mul_trunc(longint a, longint b, int s);
		bit         neg;
		bit [63:0]  ua, ub;
		bit [127:0] p, m;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'b0, ua} * {64'b0, ub};
		m = p >> s;
		if (neg && m > 128'h80000000) m = 128'h80000000;
		if (!neg && m > 128'h7fffffff) m = 128'h7fffffff;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint q30_to_q16(longint v);
		if (v >= 0) return (v + 8192) >>> 14;
		return -((-v + 8192) >>> 14);
	endfunction

	task automatic cordic_sin_cos(input bit [31:0] ang, output longint s, output longint c);
		bit        flip;
		bit [31:0] p;
		longint    x, y, z, nx, dx, dy;
		flip = ang[31] ^ ang[30];
		p = flip ? ang + 32'h80000000 : ang;
		z = longint'(signed'(p));
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				nx = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
			end else begin
				nx = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
			end
			x = nx;
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = sat32(q30_to_q16(y));
		c = sat32(q30_to_q16(x));
	endtask

	task automatic hopf_step(input ahos_in_t b, output ahos_out_t r);
		longint    err, order, s0, c0, s1, c1, t, phid, rad, adot, pos, speed;
		bit [63:0] turns;
		if (b.new_order_valid) osc_order = longint'(b.new_order);
		order = osc_order;
		err = sat32(longint'(b.measured_position) - order);
		cordic_sin_cos(osc_phase, s0, c0);
		t = mul_trunc(mul_trunc(err, c0, 16), longint'(g_freq), 16);
		osc_freq = sat32(osc_freq + mul_trunc(t, longint'(g_dt), 32));
		phid = sat32(osc_freq - t);
		rad = mul_trunc(phid, longint'(g_dt), 32);
		turns = 64'(rad) * 64'(RAD_TO_TURN);
		osc_phase = turns[47:16];
		cordic_sin_cos(osc_phase, s1, c1);
		adot = mul_trunc(mul_trunc(err, s1, 16), longint'(g_amp), 16);
		osc_amp = sat32(osc_amp + mul_trunc(adot, longint'(g_dt), 32));
		pos = mul_trunc(osc_amp, s1, 16);
		speed = mul_trunc(sat32(pos - order), longint'(g_inv_dt), 16);
		osc_order = pos;
		r.position_order = pos[31:0];
		r.speed_order = speed[31:0];
		r.phase_out = osc_phase;
		r.amplitude_out = osc_amp[31:0];
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_took) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_beats.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		ahos_out_t want, r;
		in_took = arst_n && in_valid && !in_stall;
		if (in_took) begin
			hopf_step(in_data, r);
			expected_beats.push_back(r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				if (out_data.position_order !== want.position_order)
					report_mismatch("position_order", out_data.position_order,
						want.position_order);
				if (out_data.speed_order !== want.speed_order)
					report_mismatch("speed_order", out_data.speed_order, want.speed_order);
				if (out_data.phase_out !== want.phase_out)
					report_mismatch("phase_out", out_data.phase_out, want.phase_out);
				if (out_data.amplitude_out !== want.amplitude_out)
					report_mismatch("amplitude_out", out_data.amplitude_out,
						want.amplitude_out);
			end
		end
		if (in_took || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("FAIL adaptive_hopf_oscillator_step_core");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(32'h60000)) - 32'sh30000;
		endcase
	endfunction

	function automatic ahos_in_t make_beat(logic signed [31:0] meas, logic ov,
			logic signed [31:0] ord);
		ahos_in_t b;
		b.measured_position = meas;
		b.new_order_valid = ov;
		b.new_order = ord;
		return b;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pending_beats.push_back(make_beat(pick_value(), ($urandom_range(9) < 3),
				($urandom_range(1) ? pick_value() : $urandom)));
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input bit [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FREQ_GAIN: g_freq = val;
			REG_AMP_GAIN: g_amp = val;
			REG_TIME_STEP: g_dt = val;
			REG_INV_TIME_STEP: g_inv_dt = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input bit [31:0] fg, input bit [31:0] ag, input bit [31:0] dt,
			input bit [31:0] idt);
		write_reg(REG_FREQ_GAIN, fg);
		write_reg(REG_AMP_GAIN, ag);
		write_reg(REG_TIME_STEP, dt);
		write_reg(REG_INV_TIME_STEP, idt);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		g_freq = FREQ_GAIN_RST;
		g_amp = AMP_GAIN_RST;
		g_dt = TIME_STEP_RST;
		g_inv_dt = INV_TIME_STEP_RST;
		osc_freq = 0;
		osc_amp = 0;
		osc_order = 0;
		osc_phase = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_beats.push_back(make_beat(32'sh00010000, 1'b0, 32'sh7fffffff));
		pending_beats.push_back(make_beat(32'sh7fffffff, 1'b0, 32'sh0));
		pending_beats.push_back(make_beat(32'sh80000000, 1'b0, 32'sh0));
		pending_beats.push_back(make_beat(32'sh0, 1'b1, 32'sh7fffffff));
		pending_beats.push_back(make_beat(32'sh80000000, 1'b1, 32'sh7fffffff));
		pending_beats.push_back(make_beat(32'sh7fffffff, 1'b1, 32'sh80000000));
		pending_beats.push_back(make_beat(-32'sh1, 1'b1, 32'sh1));
		pending_beats.push_back(make_beat(32'sh0, 1'b0, -32'sh1));
		pending_beats.push_back(make_beat(32'sh00020000, 1'b1, -32'sh00020000));
		for (int i = 0; i < 6; i++)
			pending_beats.push_back(make_beat(32'sh00018000, 1'b0, $urandom));
		drain();

		write_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		for (int i = 0; i < 8; i++)
			pending_beats.push_back(make_beat(pick_value(), i[0], pick_value()));
		drain();

		write_all(32'h0, 32'h0, 32'h0, 32'h0);
		queue_random(40);
		drain();

		write_all(32'h00040000, 32'h00020000, 32'd42949673, 32'd6553600);
		queue_random(250);
		drain();

		snd_idle_pct = 59;
		queue_random(200);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct = 59;
		write_all($urandom, $urandom_range(32'h100000), $urandom_range(32'd200000000),
			$urandom);
		queue_random(200);
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		drain();

		snd_idle_pct = 36;
		rcv_idle_pct = 36;
		write_all(FREQ_GAIN_RST, AMP_GAIN_RST, TIME_STEP_RST, INV_TIME_STEP_RST);
		queue_random(200);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_all(32'h00008000, 32'h00030000, 32'd429496730, 32'd655360);
		queue_random(140);
		drain();

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("PASS adaptive_hopf_oscillator_step_core");
		end else begin
			$display("FAIL adaptive_hopf_oscillator_step_core");
		end
		$finish;
	end

endmodule
